@@ src/assert_macros.svh @@
// Assertion shorthands for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ATILT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("atilt: implication check failed");

// Implication with a fixed delay in cycles.
`define ATILT_ASSERT_DLY(lbl, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("atilt: delayed check failed");

// Condition that must never hold.
`define ATILT_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("atilt: forbidden condition seen");

`endif

@@ src/atilt_pkg.sv @@
package atilt_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int ANGLE_FRAC_BITS   = 8;

    localparam int TABLE_LEN  = 24;
    localparam int ITERS      = (CORDIC_ITERATIONS > TABLE_LEN) ? TABLE_LEN : CORDIC_ITERATIONS;
    localparam int SHIFT_W    = $clog2(TABLE_LEN);

    localparam int DATA_W     = 34;
    localparam int ANG_W      = 32;
    localparam int IN_W       = 16;
    localparam int DATA_SHIFT = 14;

    localparam int ACC_FRAC   = 24;
    localparam int RND_SH     = ACC_FRAC - ANGLE_FRAC_BITS;

    localparam int MAG_W      = 32;
    localparam int GAIN_W     = 30;
    localparam int GAIN_SHIFT = 30;
    localparam int PROD_W     = MAG_W + GAIN_W;
    localparam logic [GAIN_W-1:0] GAIN_INV_Q30 = 30'd652032874;

    localparam int ANGLE_LIM  = 90 * (1 << ANGLE_FRAC_BITS);
    localparam int TILT_MAX   = (ANGLE_LIM > 32767) ? 32767 : ANGLE_LIM;
    localparam int TILT_MIN   = (-ANGLE_LIM < -32768) ? -32768 : -ANGLE_LIM;

    // pass 1 row, two gain stages, pass 2 row, output register
    localparam int LATENCY    = 2 * ITERS + 3;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [ANG_W-1:0]  ang_t;

    typedef struct packed {
        logic                   valid;
        logic                   xy_zero;
        logic signed [IN_W-1:0] az;
    } tag_t;

    // atan(2^-i) in degrees, Q24
    localparam ang_t ATAN_TABLE [TABLE_LEN] = '{
        32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
        32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
        32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
        32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
        32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
        32'sd917,       32'sd458,       32'sd229,       32'sd115
    };

endpackage

@@ src/atilt_cell.sv @@
module atilt_cell import atilt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [SHIFT_W-1:0] shift,
    input  ang_t               atan_step,
    input  data_t              prev_x,
    input  data_t              prev_y,
    input  ang_t               prev_ang,
    input  tag_t               prev_tag,
    output data_t              x,
    output data_t              y,
    output ang_t               ang,
    output tag_t               tag
);

    data_t dx;
    data_t dy;
    data_t x_next;
    data_t y_next;
    ang_t  ang_next;
    data_t x_reg;
    data_t y_reg;
    ang_t  ang_reg;
    tag_t  tag_reg;

    always_comb
    begin
        dx = prev_y >>> shift;
        dy = prev_x >>> shift;
        if (!prev_y[DATA_W-1])
        begin
            x_next   = prev_x + dx;
            y_next   = prev_y - dy;
            ang_next = prev_ang + atan_step;
        end
        else
        begin
            x_next   = prev_x - dx;
            y_next   = prev_y + dy;
            ang_next = prev_ang - atan_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= prev_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        ang_reg <= ang_next;
    end

    assign x   = x_reg;
    assign y   = y_reg;
    assign ang = ang_reg;
    assign tag = tag_reg;

endmodule

@@ src/atilt_pass.sv @@
module atilt_pass import atilt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  data_t src_x,
    input  data_t src_y,
    input  tag_t  src_tag,
    output data_t x,
    output ang_t  ang,
    output tag_t  tag
);

    data_t chain_x   [ITERS+1];
    data_t chain_y   [ITERS+1];
    ang_t  chain_ang [ITERS+1];
    tag_t  chain_tag [ITERS+1];

    assign chain_x[0]   = src_x;
    assign chain_y[0]   = src_y;
    assign chain_ang[0] = '0;
    assign chain_tag[0] = src_tag;

    for (genvar i = 0; i < ITERS; i++)
    begin : g_cell
        atilt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (SHIFT_W'(i)),
            .atan_step(ATAN_TABLE[i]),
            .prev_x   (chain_x[i]),
            .prev_y   (chain_y[i]),
            .prev_ang (chain_ang[i]),
            .prev_tag (chain_tag[i]),
            .x        (chain_x[i+1]),
            .y        (chain_y[i+1]),
            .ang      (chain_ang[i+1]),
            .tag      (chain_tag[i+1])
        );
    end

    assign x   = chain_x[ITERS];
    assign ang = chain_ang[ITERS];
    assign tag = chain_tag[ITERS];

endmodule

@@ src/atilt_gain.sv @@
module atilt_gain import atilt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  data_t mag,
    input  tag_t  src_tag,
    output data_t x,
    output data_t y,
    output tag_t  tag
);

    localparam logic [PROD_W:0] ROUND_HALF = (PROD_W+1)'(1) << (GAIN_SHIFT - 1);

    logic [PROD_W-1:0] prod_next;
    logic [PROD_W-1:0] prod_reg;
    tag_t              tag1_reg;
    logic [PROD_W:0]   rnd_sum;
    data_t             x_next;
    data_t             y_next;
    data_t             x_reg;
    data_t             y_reg;
    tag_t              tag2_reg;

    // magnitude from pass 1 is nonnegative and below 2^32
    assign prod_next = PROD_W'(mag[MAG_W-1:0]) * PROD_W'(GAIN_INV_Q30);
    assign rnd_sum   = {1'b0, prod_reg} + ROUND_HALF;
    assign x_next    = DATA_W'(rnd_sum[PROD_W:GAIN_SHIFT]);
    assign y_next    = DATA_W'(tag1_reg.az) <<< DATA_SHIFT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else
        begin
            tag1_reg <= src_tag;
            tag2_reg <= tag1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
    end

    assign x   = x_reg;
    assign y   = y_reg;
    assign tag = tag2_reg;

endmodule

@@ src/accel_tilt_angle_core.sv @@
// channel  | handshake         | payload
// ---------+-------------------+-------------------------------------
// sample   | start, busy       | accel_x, accel_y, accel_z
// result   | done (one cycle)  | tilt_angle, zero_vector
//
// One item per cycle; busy stays low. Each sample passes one CORDIC cell per
// iteration in each pass, two gain stages and one output register. Reset clears
// only the tags in the pipe (valid, xy_zero, az) and done, not the data.
// Results come out on done for one cycle; the receiver cannot stall.
module accel_tilt_angle_core import atilt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic signed [IN_W-1:0] accel_x,
    input  logic signed [IN_W-1:0] accel_y,
    input  logic signed [IN_W-1:0] accel_z,
    output logic                   done,
    output logic signed [15:0]     tilt_angle,
    output logic                   zero_vector
);

    localparam logic signed [ANG_W:0] RND_HALF = (ANG_W+1)'(1) <<< (RND_SH - 1);
    localparam logic signed [ANG_W:0] HI       = (ANG_W+1)'(TILT_MAX);
    localparam logic signed [ANG_W:0] LO       = (ANG_W+1)'(TILT_MIN);

    logic                  accept;
    data_t                 ax_ext;
    data_t                 p1_x;
    data_t                 p1_y;
    tag_t                  p1_tag;
    data_t                 mag;
    tag_t                  mag_tag;
    data_t                 p2_x;
    data_t                 p2_y;
    tag_t                  p2_tag;
    ang_t                  p2_ang;
    tag_t                  end_tag;
    logic signed [ANG_W:0] rnd;
    logic signed [ANG_W:0] clamped;
    logic signed [15:0]    tilt_next;
    logic                  zero_next;
    logic                  done_reg;
    logic signed [15:0]    tilt_reg;
    logic                  zero_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign ax_ext         = DATA_W'(accel_x);
    assign p1_x           = (ax_ext[DATA_W-1] ? -ax_ext : ax_ext) <<< DATA_SHIFT;
    assign p1_y           = DATA_W'(accel_y) <<< DATA_SHIFT;
    assign p1_tag.valid   = accept;
    assign p1_tag.xy_zero = (accel_x == '0) && (accel_y == '0);
    assign p1_tag.az      = accel_z;

    atilt_pass u_pass_xy (
        .clk    (clk),
        .rst_n  (rst_n),
        .src_x  (p1_x),
        .src_y  (p1_y),
        .src_tag(p1_tag),
        .x      (mag),
        .ang    (),
        .tag    (mag_tag)
    );

    atilt_gain u_gain (
        .clk    (clk),
        .rst_n  (rst_n),
        .mag    (mag),
        .src_tag(mag_tag),
        .x      (p2_x),
        .y      (p2_y),
        .tag    (p2_tag)
    );

    atilt_pass u_pass_z (
        .clk    (clk),
        .rst_n  (rst_n),
        .src_x  (p2_x),
        .src_y  (p2_y),
        .src_tag(p2_tag),
        .x      (),
        .ang    (p2_ang),
        .tag    (end_tag)
    );

    always_comb
    begin
        rnd = ((ANG_W+1)'(p2_ang) + RND_HALF) >>> RND_SH;
        if (rnd > HI)
        begin
            clamped = HI;
        end
        else if (rnd < LO)
        begin
            clamped = LO;
        end
        else
        begin
            clamped = rnd;
        end
        if (end_tag.xy_zero)
        begin
            clamped = end_tag.az[IN_W-1] ? LO : HI;
        end
        tilt_next = clamped[15:0];
        zero_next = end_tag.xy_zero && (end_tag.az == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= end_tag.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tilt_reg <= tilt_next;
        zero_reg <= zero_next;
    end

    assign done        = done_reg;
    assign tilt_angle  = tilt_reg;
    assign zero_vector = zero_reg;

endmodule

@@ src/atilt_checker.sv @@
`include "assert_macros.svh"

module atilt_checker import atilt_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [15:0] tilt_angle,
    input logic               zero_vector
);

    `ATILT_ASSERT_NEVER(a_never_busy, busy)
    `ATILT_ASSERT_DLY(a_latency, start && !busy, LATENCY, done)
    `ATILT_ASSERT_IMP(a_range, done, (int'(tilt_angle) <= TILT_MAX) && (int'(tilt_angle) >= TILT_MIN))
    `ATILT_ASSERT_IMP(a_zero_up, done && zero_vector, int'(tilt_angle) == TILT_MAX)

endmodule

bind accel_tilt_angle_core atilt_checker u_atilt_checker (.*);
